@@ rtl/tmcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcf_pkg
// Shared types and codes for the tile map camera fetch block.
// ----------------------------------------------------------------------------
package tmcf_pkg;

  // Request codes carried by req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_DRAW  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TILE_WIDTH      = 3'd0,
    REG_TILE_HEIGHT     = 3'd1,
    REG_MAP_WIDTH       = 3'd2,
    REG_MAP_HEIGHT      = 3'd3,
    REG_TILESET_COLUMNS = 3'd4,
    REG_TILE_COUNT      = 3'd5,
    REG_VIEW_WIDTH      = 3'd6,
    REG_VIEW_HEIGHT     = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 11;

  // Iterative divider: one quotient bit per cycle over a 16-bit dividend.
  localparam int DIV_STEPS = 16;

  // Reciprocal of the tileset column count is floor(2^RECIP_SHIFT / columns).
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Width used for map sizes after clamping to the store (up to 4096).
  localparam int SZ_W = 13;

  // Per-tile data traveling down the fetch pipeline next to the map read.
  typedef struct packed {
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic        last;
  } tile_t;

endpackage

@@ rtl/tile_map_camera_fetch_top.sv @@
// ----------------------------------------------------------------------------
// tile_map_camera_fetch_top
// Tile map store with camera-window culling and tileset source lookup.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | req_type map_row map_col tile_value
//           |                        | camera_x camera_y origin_x origin_y
//  out      | out_valid / out_ready  | dest_x dest_y src_left src_top
//           |                        | visible last
//  cfg      | cfg_we (no wait)       | cfg_index cfg_data
//
// A write item's map entry is written at the accept edge.
// A draw item first runs set-up (two rounds of bit-serial division for the
// camera and viewport spans, run on three parallel divider lanes, plus the
// span and base-address steps), then issues one map read per cycle while
// out_ready does not stall the output, for N tiles (N up to VIEW_TILES
// squared). The single read port of the map memory sets the
// one-tile-per-cycle issue rate. Results leave a four-stage pipeline (read,
// reciprocal multiply, remainder fix-up, source multiply).
// in_ready rises again as soon as the last read of a draw is issued; tiles
// still in the pipeline drain behind it in order.
// Reset puts control state in IDLE and loads configuration defaults; the map
// memory is not cleared. A stall on out_ready freezes the whole fetch
// pipeline, including the read data register, and holds the issue sequencer.
// ----------------------------------------------------------------------------
module tile_map_camera_fetch_top #(
  parameter int MAP_COLS   = 256,
  parameter int MAP_ROWS   = 64,
  parameter int VIEW_TILES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [5:0]                          map_row,
  input  logic [7:0]                          map_col,
  input  logic signed [10:0]                  tile_value,
  input  logic [15:0]                         camera_x,
  input  logic [15:0]                         camera_y,
  input  logic signed [15:0]                  origin_x,
  input  logic signed [15:0]                  origin_y,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  dest_x,
  output logic signed [15:0]                  dest_y,
  output logic [11:0]                         src_left,
  output logic [15:0]                         src_top,
  output logic                                visible,
  output logic                                last,
  // configuration
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [tmcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int RW     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int CNT_W  = $clog2(VIEW_TILES + 1);
  localparam int NLANE  = 3;
  localparam int LANE_X = 0;   // camera_x, then view_width, over tile_width
  localparam int LANE_Y = 1;   // camera_y, then view_height, over tile_height
  localparam int LANE_R = 2;   // reciprocal of tileset_columns

  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAP_COLS);
  localparam logic [tmcf_pkg::SZ_W-1:0] COLS_SZ = tmcf_pkg::SZ_W'(MAP_COLS);
  localparam logic [tmcf_pkg::SZ_W-1:0] ROWS_SZ = tmcf_pkg::SZ_W'(MAP_ROWS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0]  tile_width, tile_height, map_height, tileset_columns;
  logic [8:0]  map_width;
  logic [10:0] tile_count, view_width, view_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width      <= 7'd16;
      tile_height     <= 7'd16;
      map_width       <= 9'd256;
      map_height      <= 7'd64;
      tileset_columns <= 7'd16;
      tile_count      <= 11'd256;
      view_width      <= 11'd128;
      view_height     <= 11'd128;
    end else if (cfg_we) begin
      unique case (tmcf_pkg::cfg_reg_t'(cfg_index))
        tmcf_pkg::REG_TILE_WIDTH:      tile_width      <= cfg_data[6:0];
        tmcf_pkg::REG_TILE_HEIGHT:     tile_height     <= cfg_data[6:0];
        tmcf_pkg::REG_MAP_WIDTH:       map_width       <= cfg_data[8:0];
        tmcf_pkg::REG_MAP_HEIGHT:      map_height      <= cfg_data[6:0];
        tmcf_pkg::REG_TILESET_COLUMNS: tileset_columns <= cfg_data[6:0];
        tmcf_pkg::REG_TILE_COUNT:      tile_count      <= cfg_data;
        tmcf_pkg::REG_VIEW_WIDTH:      view_width      <= cfg_data;
        tmcf_pkg::REG_VIEW_HEIGHT:     view_height     <= cfg_data;
      endcase
    end
  end

  // Map sizes clamped to the store.
  logic [tmcf_pkg::SZ_W-1:0] mw, mh;
  assign mw = (tmcf_pkg::SZ_W'(map_width) < COLS_SZ) ? tmcf_pkg::SZ_W'(map_width) : COLS_SZ;
  assign mh = (tmcf_pkg::SZ_W'(map_height) < ROWS_SZ) ? tmcf_pkg::SZ_W'(map_height) : ROWS_SZ;

  // --------------------------------------------------------------------------
  // Handshake and pipeline advance
  // --------------------------------------------------------------------------
  typedef enum logic [2:0] {
    IDLE, DIV_CAM, LOAD_VIEW, DIV_VIEW, SPAN, BASE, RUN
  } state_t;

  state_t state;
  logic   in_acc, adv, issue;

  assign in_ready = (state == IDLE);
  assign in_acc   = in_valid && in_ready;
  assign adv      = !out_valid || out_ready;
  assign issue    = (state == RUN) && adv;

  // --------------------------------------------------------------------------
  // Map write address and range check
  // --------------------------------------------------------------------------
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign wr_en   = in_acc && (req_type == tmcf_pkg::REQ_WRITE) &&
                   (32'(map_row) < 32'(MAP_ROWS)) && (32'(map_col) < 32'(MAP_COLS));
  assign wr_addr = ADDR_W'(32'(map_row) * 32'(MAP_COLS) + 32'(map_col));

  // --------------------------------------------------------------------------
  // Divider lanes: restoring, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [15:0] dq    [NLANE];   // dividend shifting out, quotient shifting in
  logic [6:0]  dr    [NLANE];   // partial remainder
  logic [6:0]  dd    [NLANE];   // divisor
  logic [7:0]  rsh   [NLANE];
  logic        dge   [NLANE];
  logic [7:0]  rnext [NLANE];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      rsh[i]   = {dr[i], dq[i][15]};
      dge[i]   = rsh[i] >= {1'b0, dd[i]};
      rnext[i] = dge[i] ? (rsh[i] - {1'b0, dd[i]}) : rsh[i];
    end
  end

  // --------------------------------------------------------------------------
  // Span of one axis: last cell after map clamp and window cap
  // --------------------------------------------------------------------------
  function automatic logic [17:0] span_last(input logic [15:0] f,
                                            input logic [15:0] vq,
                                            input logic [tmcf_pkg::SZ_W-1:0] msz);
    logic [17:0] l;
    logic [17:0] cap;
    l   = 18'(vq) + 18'(f) + 18'd1;
    cap = 18'(f) + 18'(VIEW_TILES) - 18'd1;
    if (l >= 18'(msz)) l = 18'(msz) - 18'd1;
    if (l > cap) l = cap;
    return l;
  endfunction

  logic [15:0]               cx_q, cy_q;
  logic [17:0]               lx, ly;
  logic                      span_empty;

  assign lx = span_last(cx_q, dq[LANE_X], mw);
  assign ly = span_last(cy_q, dq[LANE_Y], mh);
  assign span_empty = (18'(cx_q) > lx) || (18'(cy_q) > ly);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [3:0]                  bit_cnt;
  logic [15:0]                 org_x, org_y, x0, y0;
  logic [tmcf_pkg::RECIP_W-1:0] recip;
  logic [CW-1:0]               c0;
  logic [RW-1:0]               r0;
  logic [CNT_W-1:0]            ncols_m1, nrows_m1, ci, ri;
  logic [ADDR_W-1:0]           row_addr, cur_addr;
  logic [15:0]                 col_dx, row_dy;
  logic                        size_zero;

  assign size_zero = (tile_width == 7'd0) || (tile_height == 7'd0) ||
                     (mw == '0) || (mh == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      bit_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_acc && (req_type == tmcf_pkg::REQ_DRAW) && !size_zero) begin
            dq[LANE_X] <= camera_x;
            dd[LANE_X] <= tile_width;
            dq[LANE_Y] <= camera_y;
            dd[LANE_Y] <= tile_height;
            dq[LANE_R] <= 16'(1 << tmcf_pkg::RECIP_SHIFT);
            dd[LANE_R] <= tileset_columns;
            for (int i = 0; i < NLANE; i++) dr[i] <= '0;
            org_x   <= origin_x;
            org_y   <= origin_y;
            bit_cnt <= '0;
            state   <= DIV_CAM;
          end
        end
        DIV_CAM, DIV_VIEW: begin
          for (int i = 0; i < NLANE; i++) begin
            dq[i] <= {dq[i][14:0], dge[i]};
            dr[i] <= rnext[i][6:0];
          end
          bit_cnt <= bit_cnt + 4'd1;
          if (bit_cnt == 4'(tmcf_pkg::DIV_STEPS - 1)) begin
            state <= (state == DIV_CAM) ? LOAD_VIEW : SPAN;
          end
        end
        LOAD_VIEW: begin
          // Camera quotients and remainders are final; start viewport spans.
          cx_q  <= dq[LANE_X];
          cy_q  <= dq[LANE_Y];
          recip <= dq[LANE_R][tmcf_pkg::RECIP_W-1:0];
          x0    <= org_x - 16'(dr[LANE_X]);
          y0    <= org_y - 16'(dr[LANE_Y]);
          dq[LANE_X] <= 16'(view_width);
          dq[LANE_Y] <= 16'(view_height);
          for (int i = 0; i < NLANE; i++) dr[i] <= '0;
          bit_cnt <= '0;
          state   <= DIV_VIEW;
        end
        SPAN: begin
          if (span_empty) begin
            state <= IDLE;
          end else begin
            c0       <= CW'(cx_q);
            r0       <= RW'(cy_q);
            ncols_m1 <= CNT_W'(lx - 18'(cx_q));
            nrows_m1 <= CNT_W'(ly - 18'(cy_q));
            state    <= BASE;
          end
        end
        BASE: begin
          row_addr <= ADDR_W'(32'(r0) * 32'(MAP_COLS) + 32'(c0));
          cur_addr <= ADDR_W'(32'(r0) * 32'(MAP_COLS) + 32'(c0));
          ci       <= '0;
          ri       <= '0;
          col_dx   <= x0;
          row_dy   <= y0;
          state    <= RUN;
        end
        RUN: begin
          if (adv) begin
            if (ci == ncols_m1) begin
              ci       <= '0;
              col_dx   <= x0;
              row_dy   <= row_dy + 16'(tile_height);
              row_addr <= row_addr + ROW_STEP;
              cur_addr <= row_addr + ROW_STEP;
              if (ri == nrows_m1) begin
                state <= IDLE;
              end else begin
                ri <= ri + CNT_W'(1);
              end
            end else begin
              ci       <= ci + CNT_W'(1);
              col_dx   <= col_dx + 16'(tile_width);
              cur_addr <= cur_addr + ADDR_W'(1);
            end
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Map memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [10:0] map_mem [DEPTH];
  logic [10:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= tile_value;
    if (issue) rd_data <= map_mem[cur_addr];
  end

  // --------------------------------------------------------------------------
  // Fetch pipeline, frozen as a whole while the output stalls
  // --------------------------------------------------------------------------
  tmcf_pkg::tile_t s1_tile, s2_tile, s3_tile, issue_tile;
  logic            s1_v, s2_v, s3_v;
  logic [9:0]      s2_u, s2_qe, s3_q;
  logic [6:0]      s3_r;
  logic            s2_vis, s3_vis;

  assign issue_tile.dest_x = col_dx;
  assign issue_tile.dest_y = row_dy;
  assign issue_tile.last   = (ci == ncols_m1) && (ri == nrows_m1);

  // Stage 1: range check and quotient estimate from the reciprocal.
  logic                             s1_vis;
  logic [10+tmcf_pkg::RECIP_W-1:0]  s1_prod;
  assign s1_vis  = (tileset_columns != 7'd0) && !rd_data[10] &&
                   ({1'b0, rd_data[9:0]} < tile_count);
  assign s1_prod = rd_data[9:0] * recip;

  // Stage 2: remainder, one correction step (estimate is low by at most one).
  logic [16:0] s2_prod, s2_rem;
  logic        s2_fix;
  assign s2_prod = s2_qe * tileset_columns;
  assign s2_rem  = 17'(s2_u) - s2_prod;
  assign s2_fix  = s2_rem >= 17'(tileset_columns);

  // Stage 3: source rectangle corner.
  logic [13:0] s3_left;
  logic [16:0] s3_top;
  assign s3_left = s3_r * tile_width;
  assign s3_top  = s3_q * tile_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= issue;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tile <= issue_tile;

      s2_tile <= s1_tile;
      s2_u    <= rd_data[9:0];
      s2_qe   <= s1_prod[tmcf_pkg::RECIP_SHIFT +: 10];
      s2_vis  <= s1_vis;

      s3_tile <= s2_tile;
      s3_q    <= s2_fix ? (s2_qe + 10'd1) : s2_qe;
      s3_r    <= s2_fix ? 7'(s2_rem - 17'(tileset_columns)) : s2_rem[6:0];
      s3_vis  <= s2_vis;

      dest_x   <= s3_tile.dest_x;
      dest_y   <= s3_tile.dest_y;
      last     <= s3_tile.last;
      visible  <= s3_vis;
      src_left <= s3_vis ? s3_left[11:0] : 12'd0;
      src_top  <= s3_vis ? s3_top[15:0] : 16'd0;
    end
  end

endmodule
